// ===== src/ber_pkg.sv =====
`default_nettype none
package ber_pkg;

   localparam int unsigned WORD_W  = 16;
   localparam int unsigned INDEX_W = 2;

   localparam logic [INDEX_W-1:0] REG_HOLD_DELAY       = 2'd0;
   localparam logic [INDEX_W-1:0] REG_PRIMARY_PERIOD   = 2'd1;
   localparam logic [INDEX_W-1:0] REG_SECONDARY_PERIOD = 2'd2;
   localparam logic [INDEX_W-1:0] REG_BUTTON_MASK      = 2'd3;

   localparam logic [WORD_W-1:0] KEY_L1     = 16'h0004;
   localparam logic [WORD_W-1:0] KEY_R1     = 16'h0008;
   localparam logic [WORD_W-1:0] KEY_SQUARE = 16'h0080;
   localparam logic [WORD_W-1:0] KEY_UP     = 16'h1000;
   localparam logic [WORD_W-1:0] KEY_RIGHT  = 16'h2000;
   localparam logic [WORD_W-1:0] KEY_DOWN   = 16'h4000;
   localparam logic [WORD_W-1:0] KEY_LEFT   = 16'h8000;
   localparam logic [WORD_W-1:0] KEY_DPAD   = KEY_UP | KEY_RIGHT | KEY_DOWN | KEY_LEFT;
   localparam logic [WORD_W-1:0] KEY_SHLD   = KEY_L1 | KEY_R1;

   localparam logic [WORD_W-1:0] RST_HOLD_DELAY       = 16'd16;
   localparam logic [WORD_W-1:0] RST_PRIMARY_PERIOD   = 16'd4;
   localparam logic [WORD_W-1:0] RST_SECONDARY_PERIOD = 16'd8;
   localparam logic [WORD_W-1:0] RST_BUTTON_MASK      = 16'hFFFF;

   typedef struct packed {
      logic [WORD_W-1:0] hold_delay;
      logic [WORD_W-1:0] primary_period;
      logic [WORD_W-1:0] secondary_period;
      logic [WORD_W-1:0] button_mask;
   } cfg_type;

endpackage
`default_nettype wire

// ===== src/ber_cfg.sv =====
`default_nettype none
module ber_cfg (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [ber_pkg::INDEX_W-1:0]   csr_index,
   input  wire logic [ber_pkg::WORD_W-1:0]    csr_wdata,
   output ber_pkg::cfg_type                   cfg
);

   ber_pkg::cfg_type cfg_ff;
   ber_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ber_pkg::REG_HOLD_DELAY:       cfg_in.hold_delay       = csr_wdata;
            ber_pkg::REG_PRIMARY_PERIOD:   cfg_in.primary_period   = csr_wdata;
            ber_pkg::REG_SECONDARY_PERIOD: cfg_in.secondary_period = csr_wdata;
            ber_pkg::REG_BUTTON_MASK:      cfg_in.button_mask      = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_delay       <= ber_pkg::RST_HOLD_DELAY;
         cfg_ff.primary_period   <= ber_pkg::RST_PRIMARY_PERIOD;
         cfg_ff.secondary_period <= ber_pkg::RST_SECONDARY_PERIOD;
         cfg_ff.button_mask      <= ber_pkg::RST_BUTTON_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== src/ber_step.sv =====
`default_nettype none
module ber_step (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic [ber_pkg::WORD_W-1:0]    buttons,
   input  wire logic                          blocked,
   input  wire ber_pkg::cfg_type              cfg,
   output logic      [ber_pkg::WORD_W-1:0]    result
);

   localparam logic [ber_pkg::WORD_W-1:0] SAT = {ber_pkg::WORD_W{1'b1}};

   logic [ber_pkg::WORD_W-1:0] last_ff, hold_ff, prim_ff, sec_ff;
   logic [ber_pkg::WORD_W-1:0] hold_in, prim_in, sec_in;
   logic [ber_pkg::WORD_W-1:0] held, hold0, prim0, sec0;
   logic [ber_pkg::WORD_W-1:0] hold_inc, prim_inc, sec_inc, res;
   logic                       square;

   always_comb begin
      held     = buttons & (ber_pkg::KEY_SHLD | ber_pkg::KEY_DPAD);
      square   = (buttons & ber_pkg::KEY_SQUARE) != '0;
      hold0    = (buttons == '0) ? '0 : hold_ff;
      prim0    = (buttons == '0) ? '0 : prim_ff;
      sec0     = (buttons == '0) ? '0 : sec_ff;
      hold_inc = (hold0 == SAT) ? hold0 : hold0 + 1'b1;
      prim_inc = (prim0 == SAT) ? prim0 : prim0 + 1'b1;
      sec_inc  = (sec0 == SAT) ? sec0 : sec0 + 1'b1;
      hold_in  = '0;
      prim_in  = prim0;
      sec_in   = sec0;
      res      = '0;
      if (last_ff != buttons || held == '0) begin
         res = ~last_ff & buttons;
      end else begin
         hold_in = hold_inc;
         if (hold_inc == cfg.hold_delay && hold_inc != hold0) begin
            res = held;
         end
         if (hold_inc >= cfg.hold_delay) begin
            prim_in = prim_inc;
            sec_in  = sec_inc;
            if (prim_inc >= cfg.primary_period) begin
               prim_in = '0;
               res = square ? (buttons & (ber_pkg::KEY_RIGHT | ber_pkg::KEY_LEFT))
                            : (buttons & ber_pkg::KEY_DPAD);
            end
            if (sec_inc >= cfg.secondary_period) begin
               sec_in = '0;
               res = res | (square ? (buttons & (ber_pkg::KEY_SHLD | ber_pkg::KEY_UP
                                                 | ber_pkg::KEY_DOWN))
                                   : (buttons & ber_pkg::KEY_SHLD));
            end
         end else begin
            prim_in = '0;
            sec_in  = '0;
         end
      end
      result = blocked ? '0 : (res & cfg.button_mask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         hold_ff <= '0;
         prim_ff <= '0;
         sec_ff  <= '0;
      end else if (enable) begin
         last_ff <= buttons;
         hold_ff <= hold_in;
         prim_ff <= prim_in;
         sec_ff  <= sec_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/button_edge_auto_repeat_top.sv =====
// A request passes the input register and then the result register; rsp_tvalid rises
// when the result register is loaded from the input register.
// Throughput: 1 request/cycle unless rsp stalls; combinational counter/compare path.
// Backpressure on rsp stalls both stages; a free result register refills every cycle.
// Reset (synchronous, active high): pipeline empty, pad history and counters zero,
// configuration at defaults (delay 16, periods 4 and 8, mask all ones).
`default_nettype none
module button_edge_auto_repeat_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [15:0]                   req_tdata,  // [15:0] buttons
   input  wire logic [0:0]                    req_tuser,  // [0] blocked
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [15:0]                   rsp_tdata,  // [15:0] new_buttons
   input  wire logic                          csr_we,
   input  wire logic [ber_pkg::INDEX_W-1:0]   csr_index,
   input  wire logic [ber_pkg::WORD_W-1:0]    csr_wdata
);

   ber_pkg::cfg_type            cfg;
   logic                        in_valid_ff, out_valid_ff, advance;
   logic [ber_pkg::WORD_W-1:0]  in_buttons_ff, out_data_ff, result;
   logic                        in_blocked_ff;

   ber_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   ber_step u_step (
      .clock   (clock),
      .reset   (reset),
      .enable  (in_valid_ff && advance),
      .buttons (in_buttons_ff),
      .blocked (in_blocked_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_buttons_ff <= req_tdata;
         in_blocked_ff <= req_tuser[0];
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_blocked_zero: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && in_blocked_ff) |=> (rsp_tvalid && rsp_tdata == '0))
      else $error("blocked request gave a nonzero result");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_tready)
      else $error("request taken while input stage stalled");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> rsp_tvalid)
      else $error("result lost on advance");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;

   localparam int unsigned IDLE_LIMIT = 5000;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [15:0]                  req_tdata;   // [15:0] buttons
   logic [0:0]                   req_tuser;   // [0] blocked
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [15:0]                  rsp_tdata;   // [15:0] new_buttons
   logic                         csr_we;
   logic [ber_pkg::INDEX_W-1:0]  csr_index;
   logic [ber_pkg::WORD_W-1:0]   csr_wdata;

   button_edge_auto_repeat_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ber_pkg::cfg_type pad_cfg;
   logic [15:0] last_pad;
   logic [15:0] hold_cnt;
   logic [15:0] dpad_cnt;
   logic [15:0] shld_cnt;

   logic [15:0] press_queue [$];
   int unsigned err_count;
   int unsigned requests_sent;
   int unsigned presses_seen;
   int unsigned nonzero_seen;
   int unsigned settings_used;
   int unsigned idle_cycles;
   int unsigned rsp_stall;
   bit          rsp_done;
   bit          no_idle;

   logic [15:0] repeat_keys [6];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [15:0] sat_step(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [15:0] predict_press(input logic [15:0] pad, input logic blk);
      logic [15:0] prev;
      logic [15:0] held;
      logic [15:0] res;
      logic [15:0] old_hold;
      prev = last_pad;
      held = pad & (ber_pkg::KEY_SHLD | ber_pkg::KEY_DPAD);
      res  = '0;
      if (pad == 16'h0000) begin
         hold_cnt = '0;
         dpad_cnt = '0;
         shld_cnt = '0;
      end
      last_pad = pad;
      if (prev != pad || held == 16'h0000) begin
         res      = ~prev & pad;
         hold_cnt = '0;
      end else begin
         old_hold = hold_cnt;
         hold_cnt = sat_step(old_hold);
         if (hold_cnt == pad_cfg.hold_delay && hold_cnt != old_hold) res = held;
         if (hold_cnt >= pad_cfg.hold_delay) begin
            dpad_cnt = sat_step(dpad_cnt);
            shld_cnt = sat_step(shld_cnt);
            if (dpad_cnt >= pad_cfg.primary_period) begin
               dpad_cnt = '0;
               if ((pad & ber_pkg::KEY_SQUARE) != 16'h0000)
                  res = pad & (ber_pkg::KEY_RIGHT | ber_pkg::KEY_LEFT);
               else res = pad & ber_pkg::KEY_DPAD;
            end
            if (shld_cnt >= pad_cfg.secondary_period) begin
               shld_cnt = '0;
               if ((pad & ber_pkg::KEY_SQUARE) != 16'h0000)
                  res |= pad & (ber_pkg::KEY_SHLD | ber_pkg::KEY_UP | ber_pkg::KEY_DOWN);
               else res |= pad & ber_pkg::KEY_SHLD;
            end
         end else begin
            dpad_cnt = '0;
            shld_cnt = '0;
         end
      end
      res &= pad_cfg.button_mask;
      if (blk) res = '0;
      return res;
   endfunction

   task automatic send_request(input logic [15:0] pad, input logic blk);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pad;
      req_tuser  = blk;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      press_queue.push_back(predict_press(pad, blk));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_tvalid = 1'b0;
      while (press_queue.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [ber_pkg::INDEX_W-1:0] idx,
                            input logic [15:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         ber_pkg::REG_HOLD_DELAY:       pad_cfg.hold_delay       = value;
         ber_pkg::REG_PRIMARY_PERIOD:   pad_cfg.primary_period   = value;
         ber_pkg::REG_SECONDARY_PERIOD: pad_cfg.secondary_period = value;
         ber_pkg::REG_BUTTON_MASK:      pad_cfg.button_mask      = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] delay, input logic [15:0] dpad_period,
                             input logic [15:0] shld_period, input logic [15:0] mask);
      drain_pipeline();
      write_reg(ber_pkg::REG_HOLD_DELAY, delay);
      write_reg(ber_pkg::REG_PRIMARY_PERIOD, dpad_period);
      write_reg(ber_pkg::REG_SECONDARY_PERIOD, shld_period);
      write_reg(ber_pkg::REG_BUTTON_MASK, mask);
      settings_used++;
   endtask

   task automatic hold_pad(input logic [15:0] pad, input int unsigned frames);
      repeat (frames) send_request(pad, 1'b0);
   endtask

   task automatic test_edges();
      send_request(16'h0000, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'hFFFF, 1'b1);
      send_request(16'h0001, 1'b0);
      hold_pad(16'h0070, 2);
      send_request(16'hFFFF, 1'b1);
      send_request(16'h0000, 1'b0);
      drain_pipeline();
      write_reg(ber_pkg::REG_BUTTON_MASK, 16'h5555);
      send_request(16'hAAAA, 1'b0);
      send_request(16'hFFFF, 1'b0);
      drain_pipeline();
      write_reg(ber_pkg::REG_BUTTON_MASK, ber_pkg::RST_BUTTON_MASK);
   endtask

   task automatic test_repeat_timing();
      set_config(16'd2, 16'd1, 16'd2, 16'hFFFF);
      hold_pad(ber_pkg::KEY_UP | ber_pkg::KEY_L1, 4);
      hold_pad(ber_pkg::KEY_SQUARE | ber_pkg::KEY_LEFT | ber_pkg::KEY_UP | ber_pkg::KEY_R1, 4);
      send_request(16'h0000, 1'b0);
      set_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
      hold_pad(ber_pkg::KEY_RIGHT | ber_pkg::KEY_DOWN, 3);
      send_request(16'h0000, 1'b0);
   endtask

   task automatic test_long_delay();
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      no_idle = 1'b1;
      hold_pad(ber_pkg::KEY_L1 | ber_pkg::KEY_DOWN, 24);
      send_request(16'h0000, 1'b0);
      no_idle = 1'b0;
   endtask

   task automatic random_phase(input int unsigned count, input int unsigned span);
      int unsigned sent;
      int unsigned kind;
      int unsigned run;
      logic [15:0] pad;
      sent = 0;
      while (sent < count) begin
         kind    = $urandom_range(0, 9);
         no_idle = ($urandom_range(0, 3) == 0);
         if (kind <= 6) begin
            pad = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 1)
               pad &= ber_pkg::KEY_SHLD | ber_pkg::KEY_DPAD | ber_pkg::KEY_SQUARE;
            pad |= repeat_keys[3'($urandom_range(0, 5))];
            if ($urandom_range(0, 1) == 1) pad |= ber_pkg::KEY_SQUARE;
            else pad &= ~ber_pkg::KEY_SQUARE;
            run = $urandom_range(1, span);
         end else if (kind == 7) begin
            pad = 16'h0000;
            run = $urandom_range(1, 2);
         end else begin
            pad = 16'($urandom_range(0, 65535));
            run = 1;
         end
         repeat (run) begin
            if (sent < count) begin
               if (kind >= 8) pad = 16'($urandom_range(0, 65535));
               send_request(pad, $urandom_range(0, 7) == 0);
               sent++;
            end
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      logic [15:0] delay;
      logic [15:0] dpad_period;
      logic [15:0] shld_period;
      set_config(ber_pkg::RST_HOLD_DELAY, ber_pkg::RST_PRIMARY_PERIOD,
                 ber_pkg::RST_SECONDARY_PERIOD, ber_pkg::RST_BUTTON_MASK);
      random_phase(300, 40);
      set_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
      random_phase(250, 12);
      repeat (3) begin
         delay       = 16'($urandom_range(1, 6));
         dpad_period = 16'($urandom_range(1, 5));
         shld_period = 16'($urandom_range(1, 8));
         set_config(delay, dpad_period, shld_period,
                    16'($urandom_range(0, 65535)) | ber_pkg::KEY_DPAD);
         random_phase(250, delay + 3 * shld_period + 4);
      end
      set_config(16'd3, 16'd2, 16'd5, 16'h0000);
      random_phase(100, 20);
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(150, 30);
      set_config(16'd2, 16'd1, 16'd0, 16'hFFFF);
      random_phase(150, 12);
   endtask

   always @(posedge clock) begin
      rsp_done = !reset && rsp_tvalid && rsp_tready;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (rsp_done) begin
         if (press_queue.size() == 0) begin
            $display("%0t: result %h with nothing expected", $time, rsp_tdata);
            err_count++;
         end else begin
            logic [15:0] want;
            want = press_queue.pop_front();
            if (want !== rsp_tdata) begin
               $display("%0t: new_buttons mismatch, expected %h, actual %h",
                        $time, want, rsp_tdata);
               err_count++;
            end
         end
         presses_seen++;
         if (rsp_tdata != 16'h0000) nonzero_seen++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  = 0;
         rsp_tready = 1'b0;
      end else begin
         if (rsp_done) rsp_stall = no_idle ? 0 : $urandom_range(0, 7);
         if (rsp_stall > 0) begin
            rsp_tready = 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      no_idle    = 1'b0;
      requests_sent = 0;
      settings_used = 1;
      pad_cfg = '{ber_pkg::RST_HOLD_DELAY, ber_pkg::RST_PRIMARY_PERIOD,
                  ber_pkg::RST_SECONDARY_PERIOD, ber_pkg::RST_BUTTON_MASK};
      last_pad = '0;
      hold_cnt = '0;
      dpad_cnt = '0;
      shld_cnt = '0;
      repeat_keys = '{ber_pkg::KEY_L1, ber_pkg::KEY_R1, ber_pkg::KEY_UP,
                      ber_pkg::KEY_RIGHT, ber_pkg::KEY_DOWN, ber_pkg::KEY_LEFT};
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_edges();
      test_repeat_timing();
      test_long_delay();
      test_random();

      drain_pipeline();
      repeat (4) @(posedge clock);
      $display("Sent %0d pad words under %0d register settings, incl. a long hold delay.",
               requests_sent, settings_used);
      $display("Checked %0d results, %0d of them with keys set.", presses_seen, nonzero_seen);
      if (err_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
src/ber_pkg.sv
src/ber_cfg.sv
src/ber_step.sv
src/button_edge_auto_repeat_top.sv
test/tb_top.sv
